@@ rtl/thread_table_scheduler_macros.svh @@
// Assertion macros for the thread table scheduler checker.
`ifndef THREAD_TABLE_SCHEDULER_MACROS_SVH
`define THREAD_TABLE_SCHEDULER_MACROS_SVH

// Clocked assertion, off while reset is high.
`define TTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tts_pkg.sv @@
// Shared types and constants of the thread table scheduler.
package tts_pkg;

   localparam int SLOTS      = 64;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int PRIO_W     = 8;
   localparam int MAX_PRIO   = 255;
   localparam int OP_W       = 4;
   localparam int VAL_W      = 32;
   localparam int DL_W       = 32;
   localparam int RUN_W      = 32;
   localparam int SLICE_W    = 16;
   localparam int TICK_W     = 64;
   localparam int STATUS_W   = 2;
   localparam int POLICY_W   = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE  = 1'd1;

   localparam logic [SLICE_W-1:0]  SLICE_RESET = 16'd10;
   localparam logic [POLICY_W-1:0] POL_PRIO    = 2'd0;
   localparam logic [POLICY_W-1:0] POL_RR      = 2'd1;
   localparam logic [POLICY_W-1:0] POL_EDF     = 2'd2;

   localparam logic [1:0] TS_READY    = 2'd0;
   localparam logic [1:0] TS_RUNNING  = 2'd1;
   localparam logic [1:0] TS_SLEEPING = 2'd2;
   localparam logic [1:0] TS_BLOCKED  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE   = 4'd0,
      OP_DESTROY  = 4'd1,
      OP_SET_PRIO = 4'd2,
      OP_INHERIT  = 4'd3,
      OP_RESTORE  = 4'd4,
      OP_SET_DL   = 4'd5,
      OP_SLEEP    = 4'd6,
      OP_WAKE     = 4'd7,
      OP_BLOCK    = 4'd8,
      OP_YIELD    = 4'd9,
      OP_TICK     = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      SCAN_FREE,
      SCAN_WAKE,
      SCAN_PICK
   } scan_mode_type;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_TARGET,
      RD_CURRENT
   } rd_sel_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_CHECK,
      CS_EXEC,
      CS_FREE_GO,
      CS_FREE_SCAN,
      CS_CREATE_WR,
      CS_WAKE_GO,
      CS_WAKE_SCAN,
      CS_TICK_CUR,
      CS_TICK_RUN,
      CS_PICK_GO,
      CS_PICK_SCAN,
      CS_DECIDE,
      CS_SW_OLD,
      CS_SW_NEW,
      CS_DONE
   } ctl_state_type;

   typedef struct packed {
      logic          latch;
      rd_sel_type    rd_sel;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          bad_target;
      logic          exec;
      logic          create_wr;
      logic          tick_run;
      logic          decide;
      logic          sw_old;
      logic          sw_new;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   target_ok;
      logic   have_current;
      logic   scan_busy;
      logic   want_switch;
   } sts_type;

endpackage

@@ rtl/tts_ctrl.sv @@
// Sequencer that steps one operation through the scheduler datapath.
module tts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  tts_pkg::sts_type sts,
   output tts_pkg::cmd_type cmd
);
   import tts_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          needs_target;
   logic          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (sts.op) inside
         OP_DESTROY, OP_SET_PRIO, OP_INHERIT, OP_RESTORE, OP_SET_DL, OP_WAKE:
            needs_target = 1'b1;
         default:
            needs_target = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) state_in = CS_CHECK;
         end
         CS_CHECK: begin
            if (needs_target && !sts.target_ok) state_in = CS_DONE;
            else state_in = CS_EXEC;
         end
         CS_EXEC: begin
            case (sts.op)
               OP_CREATE: state_in = CS_FREE_GO;
               OP_SLEEP:  state_in = sts.have_current ? CS_PICK_GO : CS_DONE;
               OP_YIELD:  state_in = CS_PICK_GO;
               OP_TICK:   state_in = CS_WAKE_GO;
               default:   state_in = CS_DONE;
            endcase
         end
         CS_FREE_GO:   state_in = CS_FREE_SCAN;
         CS_FREE_SCAN: begin
            if (!sts.scan_busy) state_in = CS_CREATE_WR;
         end
         CS_CREATE_WR: state_in = CS_DONE;
         CS_WAKE_GO:   state_in = CS_WAKE_SCAN;
         CS_WAKE_SCAN: begin
            if (!sts.scan_busy) state_in = sts.have_current ? CS_TICK_CUR : CS_PICK_GO;
         end
         CS_TICK_CUR:  state_in = CS_TICK_RUN;
         CS_TICK_RUN:  state_in = CS_PICK_GO;
         CS_PICK_GO:   state_in = CS_PICK_SCAN;
         CS_PICK_SCAN: begin
            if (!sts.scan_busy) state_in = CS_DECIDE;
         end
         CS_DECIDE:    state_in = sts.want_switch ? CS_SW_OLD : CS_DONE;
         CS_SW_OLD:    state_in = CS_SW_NEW;
         CS_SW_NEW:    state_in = CS_DONE;
         CS_DONE: begin
            if (rsp_free) state_in = CS_IDLE;
         end
         default:      state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = RD_SCAN;
      cmd.scan_mode  = SCAN_PICK;
      req_tready     = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         CS_CHECK: begin
            cmd.rd_sel     = RD_TARGET;
            cmd.bad_target = needs_target && !sts.target_ok;
         end
         CS_EXEC:      cmd.exec = 1'b1;
         CS_FREE_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_FREE;
         end
         CS_CREATE_WR: cmd.create_wr = 1'b1;
         CS_WAKE_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_WAKE;
         end
         CS_TICK_CUR:  cmd.rd_sel = RD_CURRENT;
         CS_TICK_RUN:  cmd.tick_run = 1'b1;
         CS_PICK_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_PICK;
         end
         CS_DECIDE:    cmd.decide = 1'b1;
         CS_SW_OLD:    cmd.sw_old = 1'b1;
         CS_SW_NEW:    cmd.sw_new = 1'b1;
         CS_DONE:      cmd.rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ rtl/tts_datapath.sv @@
// Slot tables, scan unit, pick logic and result register of the scheduler.
module tts_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  tts_pkg::cmd_type                 cmd,
   output tts_pkg::sts_type                 sts,
   input  logic [tts_pkg::OP_W-1:0]         req_operation,
   input  logic [tts_pkg::SLOT_W-1:0]       req_slot,
   input  logic [tts_pkg::VAL_W-1:0]        req_value,
   input  logic                             csr_wen,
   input  logic [tts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic [tts_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tts_pkg::SLOT_W-1:0]       rsp_created_slot,
   output logic                             rsp_current_valid,
   output logic [tts_pkg::SLOT_W-1:0]       rsp_current_slot,
   output logic                             rsp_switched
);
   import tts_pkg::*;

   function automatic logic [PRIO_W-1:0] clamp_prio(input logic [VAL_W-1:0] v);
      logic [PRIO_W-1:0] r;
      if (v > VAL_W'(MAX_PRIO)) r = PRIO_W'(MAX_PRIO);
      else r = v[PRIO_W-1:0];
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
      logic [SLOT_W-1:0] r;
      if (i == SLOT_W'(SLOTS - 1)) r = '0;
      else r = i + SLOT_W'(1);
      return r;
   endfunction

   logic [1:0]         state_mem [SLOTS];
   logic [PRIO_W-1:0]  prio_mem  [SLOTS];
   logic [DL_W-1:0]    dl_mem    [SLOTS];
   logic [TICK_W-1:0]  wake_mem  [SLOTS];
   logic [RUN_W-1:0]   run_mem   [SLOTS];
   logic [SLICE_W-1:0] slice_mem [SLOTS];

   logic [1:0]         state_rd_ff;
   logic [PRIO_W-1:0]  prio_rd_ff;
   logic [DL_W-1:0]    dl_rd_ff;
   logic [TICK_W-1:0]  wake_rd_ff;
   logic [RUN_W-1:0]   run_rd_ff;
   logic [SLICE_W-1:0] slice_rd_ff;

   logic [SLOTS-1:0]    used_ff, used_in;
   logic                have_ff, have_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [TICK_W-1:0]   tick_ff;
   logic [POLICY_W-1:0] policy_ff;
   logic [SLICE_W-1:0]  dslice_ff;

   logic [OP_W-1:0]     op_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [VAL_W-1:0]    value_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]   created_ff;
   logic                switched_ff;

   logic                scan_active_ff, proc_valid_ff;
   scan_mode_type       mode_ff;
   logic [SLOT_W-1:0]   scan_idx_ff, scan_cnt_ff, proc_idx_ff;

   logic                free_found_ff;
   logic [SLOT_W-1:0]   free_idx_ff;
   logic                best_valid_ff, dl_valid_ff;
   logic [SLOT_W-1:0]   best_idx_ff, dl_idx_ff;
   logic [PRIO_W-1:0]   best_prio_ff, dl_prio_ff;
   logic [DL_W-1:0]     dl_val_ff;
   logic [1:0]          cur_st_ff;
   logic [PRIO_W-1:0]   prio_c_ff;
   logic                expire_ff;

   logic [SLOT_W-1:0]   rd_addr;
   logic                st_we, prio_we, dl_we, wake_we, run_we, slice_we;
   logic [SLOT_W-1:0]   st_wa, prio_wa, dl_wa, wake_wa, run_wa, slice_wa;
   logic [1:0]          st_wd;
   logic [PRIO_W-1:0]   prio_wd;
   logic [DL_W-1:0]     dl_wd;
   logic [TICK_W-1:0]   wake_wd;
   logic [RUN_W-1:0]    run_wd;
   logic [SLICE_W-1:0]  slice_wd;

   logic                proc_used, proc_ready;
   logic                pick_valid;
   logic [SLOT_W-1:0]   pick_idx;
   logic [PRIO_W-1:0]   pick_prio;
   logic [RUN_W-1:0]    run_inc;
   logic                preempt;
   logic                want_switch;

   assign proc_used  = used_ff[proc_idx_ff];
   assign proc_ready = proc_used && (state_rd_ff == TS_READY);
   assign run_inc    = run_rd_ff + RUN_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_TARGET:  rd_addr = slot_ff;
         RD_CURRENT: rd_addr = cur_ff;
         default:    rd_addr = scan_idx_ff;
      endcase
   end

   always_comb begin
      if (policy_ff == POL_EDF && dl_valid_ff) begin
         pick_valid = 1'b1;
         pick_idx   = dl_idx_ff;
         pick_prio  = dl_prio_ff;
      end else begin
         pick_valid = best_valid_ff;
         pick_idx   = best_idx_ff;
         pick_prio  = best_prio_ff;
      end
      preempt = pick_valid && (pick_prio > prio_c_ff);
      if (op_ff == OP_TICK && have_ff)
         want_switch = preempt || (pick_valid && expire_ff);
      else
         want_switch = pick_valid;
   end

   always_comb begin
      st_we = 1'b0;    st_wa = cur_ff;    st_wd = TS_READY;
      prio_we = 1'b0;  prio_wa = slot_ff; prio_wd = clamp_prio(value_ff);
      dl_we = 1'b0;    dl_wa = slot_ff;   dl_wd = value_ff;
      wake_we = 1'b0;  wake_wa = cur_ff;  wake_wd = tick_ff + TICK_W'(value_ff);
      run_we = 1'b0;   run_wa = cur_ff;   run_wd = '0;
      slice_we = 1'b0; slice_wa = free_idx_ff; slice_wd = dslice_ff;
      used_in = used_ff;
      have_in = have_ff;
      cur_in  = cur_ff;
      if (cmd.exec) begin
         case (op_type'(op_ff))
            OP_DESTROY: begin
               used_in[slot_ff] = 1'b0;
               if (have_ff && cur_ff == slot_ff) have_in = 1'b0;
            end
            OP_SET_PRIO: prio_we = 1'b1;
            OP_INHERIT:  prio_we = value_ff > VAL_W'(prio_rd_ff);
            OP_RESTORE: begin
               prio_we = 1'b1;
               prio_wd = PRIO_W'(1);
            end
            OP_SET_DL:   dl_we = 1'b1;
            OP_SLEEP: begin
               st_we   = have_ff;
               st_wd   = TS_SLEEPING;
               wake_we = have_ff;
            end
            OP_WAKE: begin
               st_wa = slot_ff;
               st_we = (state_rd_ff == TS_SLEEPING) || (state_rd_ff == TS_BLOCKED);
            end
            OP_BLOCK: begin
               st_we = have_ff;
               st_wd = TS_BLOCKED;
            end
            default: begin
            end
         endcase
      end
      if (cmd.create_wr && free_found_ff) begin
         used_in[free_idx_ff] = 1'b1;
         st_we = 1'b1;    st_wa = free_idx_ff;   st_wd = TS_READY;
         prio_we = 1'b1;  prio_wa = free_idx_ff; prio_wd = PRIO_W'(1);
         dl_we = 1'b1;    dl_wa = free_idx_ff;   dl_wd = '0;
         run_we = 1'b1;   run_wa = free_idx_ff;  run_wd = '0;
         slice_we = 1'b1;
      end
      if (proc_valid_ff && mode_ff == SCAN_WAKE && proc_used &&
          state_rd_ff == TS_SLEEPING && wake_rd_ff <= tick_ff) begin
         st_we = 1'b1;
         st_wa = proc_idx_ff;
         st_wd = TS_READY;
      end
      if (cmd.tick_run) begin
         run_we = 1'b1;
         run_wd = run_inc;
      end
      if (cmd.decide && op_ff == OP_TICK && have_ff && expire_ff && !preempt) begin
         run_we = 1'b1;
         run_wd = '0;
      end
      if (cmd.sw_old && have_ff && cur_st_ff == TS_RUNNING) begin
         st_we = 1'b1;
         st_wd = TS_READY;
      end
      if (cmd.sw_new) begin
         st_we   = 1'b1;
         st_wa   = pick_idx;
         st_wd   = TS_RUNNING;
         cur_in  = pick_idx;
         have_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we)    state_mem[st_wa]   <= st_wd;
      if (prio_we)  prio_mem[prio_wa]  <= prio_wd;
      if (dl_we)    dl_mem[dl_wa]      <= dl_wd;
      if (wake_we)  wake_mem[wake_wa]  <= wake_wd;
      if (run_we)   run_mem[run_wa]    <= run_wd;
      if (slice_we) slice_mem[slice_wa] <= slice_wd;
      state_rd_ff <= state_mem[rd_addr];
      prio_rd_ff  <= prio_mem[rd_addr];
      dl_rd_ff    <= dl_mem[rd_addr];
      wake_rd_ff  <= wake_mem[rd_addr];
      run_rd_ff   <= run_mem[rd_addr];
      slice_rd_ff <= slice_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= '0;
         have_ff        <= 1'b0;
         cur_ff         <= '0;
         tick_ff        <= '0;
         policy_ff      <= POL_PRIO;
         dslice_ff      <= SLICE_RESET;
         scan_active_ff <= 1'b0;
         proc_valid_ff  <= 1'b0;
      end else begin
         used_ff <= used_in;
         have_ff <= have_in;
         cur_ff  <= cur_in;
         if (cmd.exec && op_ff == OP_TICK) tick_ff <= tick_ff + TICK_W'(1);
         if (csr_wen && csr_index == CSR_POLICY) policy_ff <= csr_wdata[POLICY_W-1:0];
         if (csr_wen && csr_index == CSR_SLICE) dslice_ff <= csr_wdata[SLICE_W-1:0];
         if (cmd.scan_start) scan_active_ff <= 1'b1;
         else if (scan_active_ff && scan_cnt_ff == SLOT_W'(SLOTS - 1))
            scan_active_ff <= 1'b0;
         proc_valid_ff <= scan_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= scan_idx_ff;
      if (cmd.scan_start) begin
         mode_ff     <= cmd.scan_mode;
         scan_cnt_ff <= '0;
         scan_idx_ff <= (cmd.scan_mode == SCAN_PICK && have_ff) ? next_slot(cur_ff) : '0;
         free_found_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         dl_valid_ff   <= 1'b0;
      end else if (scan_active_ff) begin
         scan_cnt_ff <= scan_cnt_ff + SLOT_W'(1);
         scan_idx_ff <= next_slot(scan_idx_ff);
      end
      if (proc_valid_ff && mode_ff == SCAN_FREE && !proc_used && !free_found_ff) begin
         free_found_ff <= 1'b1;
         free_idx_ff   <= proc_idx_ff;
      end
      if (proc_valid_ff && mode_ff == SCAN_PICK) begin
         if (proc_idx_ff == cur_ff) cur_st_ff <= state_rd_ff;
         if (proc_ready) begin
            if (policy_ff == POL_RR) begin
               if (!best_valid_ff) begin
                  best_valid_ff <= 1'b1;
                  best_idx_ff   <= proc_idx_ff;
                  best_prio_ff  <= prio_rd_ff;
               end
            end else if (policy_ff == POL_EDF && dl_rd_ff != '0) begin
               if (!dl_valid_ff || dl_rd_ff < dl_val_ff) begin
                  dl_valid_ff <= 1'b1;
                  dl_idx_ff   <= proc_idx_ff;
                  dl_val_ff   <= dl_rd_ff;
                  dl_prio_ff  <= prio_rd_ff;
               end
            end else if (!best_valid_ff || prio_rd_ff > best_prio_ff) begin
               best_valid_ff <= 1'b1;
               best_idx_ff   <= proc_idx_ff;
               best_prio_ff  <= prio_rd_ff;
            end
         end
      end
      if (cmd.tick_run) begin
         prio_c_ff <= prio_rd_ff;
         expire_ff <= run_inc >= RUN_W'(slice_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff       <= req_operation;
         slot_ff     <= req_slot;
         value_ff    <= req_value;
         status_ff   <= STATUS_OK;
         created_ff  <= '0;
         switched_ff <= 1'b0;
      end
      if (cmd.bad_target) status_ff <= STATUS_BAD;
      if (cmd.create_wr) begin
         if (free_found_ff) created_ff <= free_idx_ff;
         else status_ff <= STATUS_NO_FREE;
      end
      if (cmd.sw_new) switched_ff <= 1'b1;
      if (cmd.rsp_load) begin
         rsp_status        <= status_ff;
         rsp_created_slot  <= created_ff;
         rsp_current_valid <= have_ff;
         rsp_current_slot  <= have_ff ? cur_ff : '0;
         rsp_switched      <= switched_ff;
      end
   end

   assign sts.op           = op_type'(op_ff);
   assign sts.target_ok    = used_ff[slot_ff];
   assign sts.have_current = have_ff;
   assign sts.scan_busy    = scan_active_ff || proc_valid_ff;
   assign sts.want_switch  = want_switch;

endmodule

@@ rtl/thread_table_scheduler.sv @@
// Top level of the thread table scheduler: sequencer plus datapath.
// One operation is handled at a time; a result waits in an output register
// while the next beat is accepted. Timing is set by the single read port
// of the slot tables, scanned one slot per cycle: destroy, priority,
// deadline, wake and block need no scan, create a free scan of 64 slots,
// yield and sleep one pick scan of 64 slots plus switch, and tick a wake
// sweep of 64 slots, a run-time update, then a pick scan.
// There is no clearing pass after reset; slot tables are written on create.
module thread_table_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // operation[3:0], slot[9:4], value[41:10], zero[47:42]
   input  logic [tts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[1:0], created_slot[7:2], current_valid[8],
   // current_slot[14:9], switched[15]
   output logic [tts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [tts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tts_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   created_slot;
   logic                current_valid;
   logic [SLOT_W-1:0]   current_slot;
   logic                switched;

   tts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tts_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_tdata[3:0]),
      .req_slot          (req_tdata[9:4]),
      .req_value         (req_tdata[41:10]),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (status),
      .rsp_created_slot  (created_slot),
      .rsp_current_valid (current_valid),
      .rsp_current_slot  (current_slot),
      .rsp_switched      (switched)
   );

   assign rsp_tdata = {switched, current_slot, current_valid, created_slot, status};

endmodule

@@ rtl/tts_checker.sv @@
// Port-level checker of the thread table scheduler and its bind.
`include "thread_table_scheduler_macros.svh"

module tts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tts_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tts_pkg::*;

   `TTS_ASSERT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")
   `TTS_ASSERT(status_code_a, clock, reset, rsp_tvalid |-> rsp_tdata[1:0] != 2'd3, "undefined status code")
   `TTS_ASSERT(cur_zero_a, clock, reset, rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[14:9] == 6'd0, "current slot set without a current thread")
   `TTS_ASSERT(created_ok_a, clock, reset, rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[7:2] == 6'd0 && !rsp_tdata[15], "failed operation reports a slot or switch")
   `TTS_ASSERT_ALWAYS(reset_idle_a, clock, reset |=> !rsp_tvalid, "result beat out of reset")

endmodule

bind thread_table_scheduler tts_checker u_tts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
